// File: rtl/core/hcbd_pkg.sv
// Package for the chunked body decoder: types, constants and the byte classifier.
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int unsigned LenBitsDefault = 32;
  localparam int unsigned FifoDepth      = 2;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  // Bytes dropped after the data of each chunk
  localparam logic [1:0] TrailerSkip = 2'd2;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_TRAIL = 3'd2,
    PH_DONE  = 3'd3,
    PH_ERROR = 3'd4
  } phase_e;

  // One classified input byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } cls_t;

  function automatic cls_t classify(input logic [7:0] b, input logic start);
    cls_t c;
    c.data    = b;
    c.start   = start;
    c.is_hex  = 1'b1;
    c.hex_val = 4'd0;
    c.is_cr   = (b == CharCr);
    c.is_lf   = (b == CharLf);
    if (b >= 8'h30 && b <= 8'h39) begin
      c.hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      c.hex_val = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      c.hex_val = 4'(b - 8'h41 + 8'd10);
    end else begin
      c.is_hex = 1'b0;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/hcbd_front.sv
// Front end: classify each accepted input byte and push it into the queue.
`timescale 1ns / 1ps

module hcbd_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    body_byte_i,
  input  logic          start_of_message_i,
  output logic          push_o,
  output hcbd_pkg::cls_t push_data_o,
  input  logic          full_i
);
  import hcbd_pkg::*;

  assign in_ready_o  = ~full_i;
  assign push_o      = in_valid_i & ~full_i;
  assign push_data_o = classify(body_byte_i, start_of_message_i);

endmodule

// File: rtl/core/hcbd_fifo.sv
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps

module hcbd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hcbd_pkg::cls_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output hcbd_pkg::cls_t head_o
);
  import hcbd_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(FifoDepth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(FifoDepth - 1);

  cls_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == DepthCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/hcbd_back.sv
// Back end: chunk parser state machine and registered result slot.
`timescale 1ns / 1ps

module hcbd_back #(
  parameter int unsigned LEN_BITS = hcbd_pkg::LenBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  hcbd_pkg::cls_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     payload_byte_o,
  output logic           has_byte_o,
  output logic           message_done_o,
  output logic           format_error_o
);
  import hcbd_pkg::*;

  phase_e              phase_q, phase_d, eff_phase;
  logic [LEN_BITS-1:0] len_q, len_d, eff_len, len_dec;
  logic                seen_q, seen_d, eff_seen;
  logic                closed_q, closed_d, eff_closed;
  logic                cr_q, cr_d, eff_cr;
  logic [1:0]          trail_q, trail_d, eff_trail, trail_dec;
  logic                len_ovf;

  logic                res_valid, res_has, res_done, res_err;
  logic [7:0]          res_byte;

  logic                out_valid_q, out_valid_d;
  logic [7:0]          byte_q;
  logic                has_q, done_q, err_q;

  // Take a queued byte whenever the result slot is free or draining
  assign pop_o = item_valid_i & (~out_valid_q | out_ready_i);

  // A start flag restarts the parser before the byte is handled
  assign eff_phase  = item_i.start ? PH_SIZE : phase_q;
  assign eff_len    = item_i.start ? '0      : len_q;
  assign eff_seen   = item_i.start ? 1'b0    : seen_q;
  assign eff_closed = item_i.start ? 1'b0    : closed_q;
  assign eff_cr     = item_i.start ? 1'b0    : cr_q;
  assign eff_trail  = item_i.start ? 2'd0    : trail_q;

  assign len_ovf   = |eff_len[LEN_BITS-1 -: 4];
  assign len_dec   = eff_len - 1'b1;
  assign trail_dec = (eff_trail != 2'd0) ? eff_trail - 1'b1 : eff_trail;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    seen_d   = seen_q;
    closed_d = closed_q;
    cr_d     = cr_q;
    trail_d  = trail_q;
    if (pop_o) begin
      phase_d  = eff_phase;
      len_d    = eff_len;
      seen_d   = eff_seen;
      closed_d = eff_closed;
      cr_d     = eff_cr;
      trail_d  = eff_trail;
      unique case (eff_phase)
        PH_SIZE: begin
          if (!eff_closed && item_i.is_hex) begin
            if (len_ovf) begin
              phase_d = PH_ERROR;
            end else begin
              len_d  = {eff_len[LEN_BITS-5:0], item_i.hex_val};
              seen_d = 1'b1;
            end
          end else if (!eff_closed && !eff_seen) begin
            closed_d = 1'b1;
            phase_d  = PH_ERROR;
          end else begin
            closed_d = 1'b1;
            if (item_i.is_lf && eff_cr) begin
              cr_d    = 1'b0;
              phase_d = (eff_len == '0) ? PH_DONE : PH_DATA;
            end else begin
              cr_d = item_i.is_cr;
            end
          end
        end
        PH_DATA: begin
          len_d = len_dec;
          if (len_dec == '0) begin
            phase_d = PH_TRAIL;
            trail_d = TrailerSkip;
          end
        end
        PH_TRAIL: begin
          trail_d = trail_dec;
          if (trail_dec == 2'd0) begin
            phase_d  = PH_SIZE;
            len_d    = '0;
            seen_d   = 1'b0;
            closed_d = 1'b0;
            cr_d     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the current byte
  always_comb begin
    res_valid = 1'b0;
    res_byte  = 8'd0;
    res_has   = 1'b0;
    res_done  = 1'b0;
    res_err   = 1'b0;
    unique case (eff_phase)
      PH_SIZE: begin
        if (!eff_closed && item_i.is_hex) begin
          res_valid = len_ovf;
          res_err   = len_ovf;
        end else if (!eff_closed && !eff_seen) begin
          res_valid = 1'b1;
          res_err   = 1'b1;
        end else if (item_i.is_lf && eff_cr && eff_len == '0) begin
          res_valid = 1'b1;
          res_done  = 1'b1;
        end
      end
      PH_DATA: begin
        res_valid = 1'b1;
        res_byte  = item_i.data;
        res_has   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (pop_o && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      len_q       <= '0;
      seen_q      <= 1'b0;
      closed_q    <= 1'b0;
      cr_q        <= 1'b0;
      trail_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      seen_q      <= seen_d;
      closed_q    <= closed_d;
      cr_q        <= cr_d;
      trail_q     <= trail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      byte_q <= res_byte;
      has_q  <= res_has;
      done_q <= res_done;
      err_q  <= res_err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = byte_q;
  assign has_byte_o     = has_q;
  assign message_done_o = done_q;
  assign format_error_o = err_q;

endmodule

// File: rtl/core/http_chunked_body_decoder.sv
// Path: an accepted byte goes into the queue; the back end pops it and registers its result.
// Throughput: one byte per cycle while the result slot is free or draining (parser step is combinational).
// Bytes that give no result (size digits, CR LF, trailer) still wait for a free or draining result slot.
// Reset: rst_ni low clears the queue, the result slot and the parser to an empty size line.
// No clearing pass; the block is ready for bytes as soon as rst_ni is released.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
  parameter int unsigned LEN_BITS = hcbd_pkg::LenBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input byte stream
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] body_byte_i,
  input  logic       start_of_message_i,
  // decoded result stream
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic       has_byte_o,
  output logic       message_done_o,
  output logic       format_error_o
);
  import hcbd_pkg::*;

  // Front end to queue: one classified byte per input transaction
  logic push;
  cls_t push_data;
  logic full;

  // Queue to back end
  logic pop;
  logic head_valid;
  cls_t head;

  // Classify the byte (hex digit value, CR, LF) as it is accepted.
  hcbd_front u_front (
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .body_byte_i        (body_byte_i),
    .start_of_message_i (start_of_message_i),
    .push_o             (push),
    .push_data_o        (push_data),
    .full_i             (full)
  );

  // Hold classified bytes so the input side keeps flowing while
  // a result waits to be taken.
  hcbd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  // Advance the chunk parser one byte per cycle while the result slot is free or draining, and register the result.
  // Bytes that produce no result are popped without touching the result slot.
  hcbd_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (head_valid),
    .item_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .has_byte_o     (has_byte_o),
    .message_done_o (message_done_o),
    .format_error_o (format_error_o)
  );

endmodule

// File: rtl/core/hcbd_checker.sv
// Port-level assertions for the chunked body decoder, bound to the top level.
`timescale 1ns / 1ps

module hcbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] body_byte_i,
  input logic       start_of_message_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_o,
  input logic       has_byte_o,
  input logic       message_done_o,
  input logic       format_error_o
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o) &&
      $stable(has_byte_o) && $stable(message_done_o) && $stable(format_error_o))
    else $error("result changed while stalled");

  // Each result is exactly one of payload, done or error
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({has_byte_o, message_done_o, format_error_o}) == 1)
    else $error("result kind not one-hot");

  // Non-payload results carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> payload_byte_o == 8'd0)
    else $error("nonzero byte on non-payload result");

  // No result comes out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

// File: tb/testbench.sv
// Testbench for http_chunked_body_decoder: directed and random chunked bodies against a predictor.
`timescale 1ns / 1ps

module testbench;
  import hcbd_pkg::*;

  localparam int unsigned LenBits     = LenBitsDefault;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned StreamItems = 1000;
  localparam int unsigned PrintLimit  = 100;
  localparam logic [7:0]  CharSemi    = 8'h3B;

  // One decoded result as the block reports it
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       message_done;
    logic       format_error;
  } decoded_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] body_byte_i;
  logic       start_of_message_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] payload_byte_o;
  logic       has_byte_o;
  logic       message_done_o;
  logic       format_error_o;

  // Predictor state: mirror of the parser inside the block
  phase_e             parse_phase;
  logic [LenBits-1:0] chunk_len;
  logic               got_digit;
  logic               digits_done;
  logic               pending_cr;
  logic [1:0]         skip_left;

  decoded_t    decoded_q[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned hold_request;
  int unsigned hold_left;
  bit          steady;
  bit          start_pending;

  http_chunked_body_decoder u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .body_byte_i        (body_byte_i),
    .start_of_message_i (start_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .payload_byte_o     (payload_byte_o),
    .has_byte_o         (has_byte_o),
    .message_done_o     (message_done_o),
    .format_error_o     (format_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_line();
    parse_phase = PH_SIZE;
    chunk_len   = '0;
    got_digit   = 1'b0;
    digits_done = 1'b0;
    pending_cr  = 1'b0;
    skip_left   = 2'd0;
  endfunction

  function automatic void queue_result(input logic [7:0] p, input logic h, input logic d,
                                       input logic e);
    decoded_t r;
    r.payload_byte = p;
    r.has_byte     = h;
    r.message_done = d;
    r.format_error = e;
    decoded_q.push_back(r);
  endfunction

  // Return {is_hex, value} for one ASCII byte
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      return 5'd0;
    end
    return {1'b1, v[3:0]};
  endfunction

  // Advance the predictor by one accepted byte; queue the result it causes, if any
  function automatic void decode_byte(input logic [7:0] b, input logic s);
    logic [4:0] hx;
    hx = hex_nibble(b);
    if (s) clear_line();
    case (parse_phase)
      PH_SIZE: begin
        if (!digits_done) begin
          if (hx[4]) begin
            // a digit that would shift bits out of the length is an overflow
            if (chunk_len[LenBits-1 -: 4] != 4'd0) begin
              parse_phase = PH_ERROR;
              queue_result(8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
              chunk_len = {chunk_len[LenBits-5:0], hx[3:0]};
              got_digit = 1'b1;
            end
            return;
          end
          digits_done = 1'b1;
          if (!got_digit) begin
            parse_phase = PH_ERROR;
            queue_result(8'h00, 1'b0, 1'b0, 1'b1);
            return;
          end
        end
        // the line ends only at an LF right after a CR
        if (b == CharLf && pending_cr) begin
          pending_cr = 1'b0;
          if (chunk_len == '0) begin
            parse_phase = PH_DONE;
            queue_result(8'h00, 1'b0, 1'b1, 1'b0);
          end else begin
            parse_phase = PH_DATA;
          end
        end else begin
          pending_cr = (b == CharCr);
        end
      end
      PH_DATA: begin
        chunk_len = chunk_len - 1'b1;
        if (chunk_len == '0) begin
          parse_phase = PH_TRAIL;
          skip_left   = TrailerSkip;
        end
        queue_result(b, 1'b1, 1'b0, 1'b0);
      end
      PH_TRAIL: begin
        if (skip_left != 2'd0) skip_left = skip_left - 2'd1;
        if (skip_left == 2'd0) clear_line();
      end
      default: begin
        // done, error and unused phases drop every byte
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after acceptance
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    if (!steady && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    body_byte_i        <= b;
    start_of_message_i <= start_pending;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_byte(b, start_pending);
    start_pending = 1'b0;
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    // mix upper and lower case letters
    return ($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  // Size line: optional leading zero, hex digits, optional extension, CR (CR) LF
  task automatic send_size_line(input logic [LenBits-1:0] len);
    int         nd;
    logic [7:0] c;
    nd = 1;
    while (nd < LenBits / 4 && (len >> (4 * nd)) != '0) nd++;
    if ($urandom_range(3) == 0) send_byte(8'h30);
    for (int i = nd - 1; i >= 0; i--) send_byte(hex_char(len[4*i +: 4]));
    if ($urandom_range(4) == 0) begin
      send_byte(CharSemi);
      // extension text may hold anything but LF, stray CRs included
      repeat ($urandom_range(0, 5)) begin
        c = 8'($urandom_range(255));
        if (c == CharLf) c = CharCr;
        send_byte(c);
      end
    end
    if ($urandom_range(7) == 0) send_byte(CharCr);
    send_byte(CharCr);
    send_byte(CharLf);
  endtask

  task automatic send_chunk(input logic [LenBits-1:0] len);
    send_size_line(len);
    repeat (len) send_byte(8'($urandom_range(255)));
    // two trailer bytes, dropped whatever they hold
    repeat (2) send_byte(8'($urandom_range(255)));
  endtask

  // Well-formed body with random content, then maybe some ignored bytes
  task automatic send_message();
    logic [LenBits-1:0] len;
    start_pending = 1'b1;
    repeat ($urandom_range(0, 3)) begin
      len = ($urandom_range(5) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
      send_chunk(len);
    end
    send_size_line('0);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
    end
  endtask

  // Noise and broken bodies: garbage, empty size line, overflow, cut short
  task automatic send_broken();
    logic [LenBits-1:0] len;
    start_pending = 1'b1;
    case ($urandom_range(3))
      0: repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
      1: begin
        send_byte(CharCr);
        send_byte(CharLf);
      end
      2: begin
        send_byte(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 10)) send_byte(hex_char(4'($urandom_range(15))));
      end
      default: begin
        len = $urandom_range(2, 16);
        send_size_line(len);
        repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(255)));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result checking
  // ---------------------------------------------------------------------------

  // Drop ready at random; a hold request keeps it low for a counted stretch
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 26);
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintLimit) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    decoded_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: byte %02h has %b done %b err %b",
                                  payload_byte_o, has_byte_o, message_done_o, format_error_o));
      end else begin
        want = decoded_q.pop_front();
        if (payload_byte_o !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %02h, want %02h",
                                    payload_byte_o, want.payload_byte));
        if (has_byte_o !== want.has_byte)
          report_mismatch($sformatf("has_byte %b, want %b", has_byte_o, want.has_byte));
        if (message_done_o !== want.message_done)
          report_mismatch($sformatf("message_done %b, want %b",
                                    message_done_o, want.message_done));
        if (format_error_o !== want.format_error)
          report_mismatch($sformatf("format_error %b, want %b",
                                    format_error_o, want.format_error));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               decoded_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-built stream: no start flag after reset, leading zero, extension,
  // CR CR LF, extreme payload bytes, trailer that looks like a line end, done,
  // ignored bytes, missing digit, and a length that overflows.
  task automatic test_directed();
    send_byte(8'h30);
    send_byte(8'h32);
    send_byte(CharSemi);
    send_byte(CharCr);
    send_byte(CharCr);
    send_byte(CharLf);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CharCr);
    send_byte(CharLf);
    send_byte(8'h30);
    send_byte(CharCr);
    send_byte(CharLf);
    send_byte(8'h35);
    start_pending = 1'b1;
    send_byte(8'h47);
    send_byte(8'h35);
    start_pending = 1'b1;
    send_byte(8'h61);
    send_byte(8'h42);
    send_byte(8'h63);
    send_byte(8'h44);
    send_byte(8'h65);
    send_byte(8'h46);
    send_byte(8'h39);
    send_byte(8'h30);
    send_byte(8'h31);
  endtask

  // Hold the receiver off during a long chunk so the block fills and stalls its input
  task automatic test_back_pressure();
    steady        = 1'b1;
    start_pending = 1'b1;
    send_size_line(LenBits'(48));
    hold_request = 40;
    repeat (48) send_byte(8'($urandom_range(255)));
    repeat (2) send_byte(8'($urandom_range(255)));
    send_size_line('0);
    steady = 1'b0;
  endtask

  // Run back to back with no idling on either side
  task automatic test_steady_stream();
    int unsigned stop_at;
    stop_at = items_sent + 150;
    steady  = 1'b1;
    while (items_sent < stop_at) send_message();
    steady = 1'b0;
  endtask

  // Mostly well-formed bodies, some noise and broken ones
  task automatic test_random_stream();
    int unsigned stop_at;
    stop_at = items_sent + StreamItems;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) send_message();
      else send_broken();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    body_byte_i        = 8'h00;
    start_of_message_i = 1'b0;
    out_ready_i        = 1'b0;
    mismatches         = 0;
    cycle_count        = 0;
    items_sent         = 0;
    hold_request       = 0;
    hold_left          = 0;
    steady             = 1'b0;
    start_pending      = 1'b0;
    clear_line();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_back_pressure();
    test_steady_stream();
    test_random_stream();
    in_valid_i <= 1'b0;

    // Drain, then give the queue and the result slot time to show any stray result
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/hcbd_pkg.sv
rtl/core/hcbd_front.sv
rtl/core/hcbd_fifo.sv
rtl/core/hcbd_back.sv
rtl/core/http_chunked_body_decoder.sv
rtl/core/hcbd_checker.sv
tb/testbench.sv
